FILE: sv/sml_pkg.sv
`timescale 1ns / 1ps
package sml_pkg;

    typedef enum logic [2:0] {
        OP_APPEND_DATA = 3'd0,
        OP_APPEND_TEXT = 3'd1,
        OP_WRITE_DATA  = 3'd2,
        OP_READ_DATA   = 3'd3,
        OP_READ_TEXT   = 3'd4,
        OP_BIND_LABEL  = 3'd5,
        OP_BIND_HERE   = 3'd6,
        OP_LABEL_ADDR  = 3'd7
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DATA_FULL = 3'd1,
        ST_TEXT_FULL = 3'd2,
        ST_INVALID   = 3'd3,
        ST_NO_LABEL  = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ
    } t_state;

    localparam logic [1:0] CFG_DATA_START = 2'd0;
    localparam logic [1:0] CFG_TEXT_START = 2'd1;
    localparam logic [1:0] CFG_MEM_SIZE   = 2'd2;

    localparam logic [12:0] ADDR_MAX = 13'h1FFF;

    typedef struct packed {
        logic [2:0]         operation;
        logic               by_label;
        logic [11:0]        word_address;
        logic [7:0]         label_id;
        logic signed [63:0] word_value;
    } t_sml_in;

    typedef struct packed {
        logic signed [63:0] read_value;
        logic [12:0]        result_address;
        logic [2:0]         status;
    } t_sml_out;

    typedef struct packed {
        logic        en;
        logic [7:0]  id;
        logic [12:0] target;
    } t_lbl_wr;

    typedef struct packed {
        logic        valid;
        logic [12:0] target;
    } t_lbl_rd;

endpackage

FILE: sv/sml_labels.sv
`timescale 1ns / 1ps
module sml_labels
    import sml_pkg::*;
#(
    parameter int LABEL_DEPTH = 256
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en,
    input  logic [7:0] i_rd_id,
    input  t_lbl_wr    i_wr,
    output t_lbl_rd    o_rd
);

    localparam int LV = (LABEL_DEPTH < 256) ? LABEL_DEPTH : 256;
    localparam int LW = $clog2(LV);

    logic [12:0]   mem_target [LV];
    logic [LV-1:0] r_valid;
    logic          r_rd_valid;
    logic [12:0]   r_rd_target;

    logic          w_rd_in_range;
    logic          w_wr_in_range;
    logic [LW-1:0] w_rd_idx;
    logic [LW-1:0] w_wr_idx;

    assign w_rd_in_range = 32'(i_rd_id) < 32'(LV);
    assign w_wr_in_range = 32'(i_wr.id) < 32'(LV);
    assign w_rd_idx      = i_rd_id[LW-1:0];
    assign w_wr_idx      = i_wr.id[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en && w_wr_in_range) begin
                r_valid[w_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= w_rd_in_range && r_valid[w_rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && w_wr_in_range) begin
            mem_target[w_wr_idx] <= i_wr.target;
        end
        if (i_rd_en) begin
            r_rd_target <= mem_target[w_rd_idx];
        end
    end

    assign o_rd.valid  = r_rd_valid;
    assign o_rd.target = r_rd_target;

endmodule

FILE: sv/sectioned_memory_with_labels_unit.sv
`timescale 1ns / 1ps
// An accepted transaction is registered together with its label table read, executed
// in S_EXEC, and its result registered onto o_done; a successful read first passes
// S_READ, which waits on the word memory. No new transaction is taken while busy;
// the label table read and the word memory read are done in turn on registered RAMs.
// Reset is synchronous and active low; it clears fill counts and label valid bits.
// Read values are not held: the receiver takes each one on the cycle o_done is high.
module sectioned_memory_with_labels_unit
    import sml_pkg::*;
#(
    parameter int MEM_DEPTH   = 4096,
    parameter int LABEL_DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_sml_in     i_in,
    output logic        o_done,
    output t_sml_out    o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam int AW = $clog2(MEM_DEPTH);

    t_state      r_state, n_state;
    t_sml_in     r_in;
    logic [12:0] r_data_start, r_text_start, r_mem_size;
    logic [12:0] r_data_fill, n_data_fill;
    logic [12:0] r_text_fill, n_text_fill;
    logic        r_done, n_done;
    logic        r_rd_flag, n_rd_flag;
    logic [12:0] r_res_addr, n_res_addr;
    logic [2:0]  r_status, n_status;
    logic [63:0] r_rdata;
    logic [63:0] mem_words [MEM_DEPTH];

    t_lbl_wr     w_lbl_wr;
    t_lbl_rd     w_lbl_rd;
    logic        w_accept;
    t_op         w_op;
    logic [13:0] w_app_d, w_app_t;
    logic        w_app_d_ok, w_app_t_ok;
    logic [12:0] w_acc, w_sec_start, w_sec_fill, w_here;
    logic        w_in_sec, w_lbl_in_range;
    logic [31:0] w_mem_addr;
    logic [AW-1:0] w_mem_idx;
    logic        w_mem_we, w_mem_re;

    assign w_accept    = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    sml_labels #(
        .LABEL_DEPTH(LABEL_DEPTH)
    ) u_labels (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_rd_en(w_accept),
        .i_rd_id(i_in.label_id),
        .i_wr   (w_lbl_wr),
        .o_rd   (w_lbl_rd)
    );

    assign w_op       = t_op'(r_in.operation);
    assign w_app_d    = 14'(r_data_start) + 14'(r_data_fill);
    assign w_app_t    = 14'(r_text_start) + 14'(r_text_fill);
    assign w_app_d_ok = (w_app_d < 14'(r_text_start)) && (32'(w_app_d) < 32'(MEM_DEPTH));
    assign w_app_t_ok = (w_app_t < 14'(r_mem_size)) && (32'(w_app_t) < 32'(MEM_DEPTH));
    assign w_here     = (w_app_t > 14'(ADDR_MAX)) ? ADDR_MAX : w_app_t[12:0];
    assign w_acc      = r_in.by_label ? w_lbl_rd.target : {1'b0, r_in.word_address};
    assign w_sec_start = (w_op == OP_READ_TEXT) ? r_text_start : r_data_start;
    assign w_sec_fill  = (w_op == OP_READ_TEXT) ? r_text_fill : r_data_fill;
    assign w_in_sec   = (w_acc >= w_sec_start)
                     && (14'(w_acc) < 14'(w_sec_start) + 14'(w_sec_fill))
                     && (32'(w_acc) < 32'(MEM_DEPTH));
    assign w_lbl_in_range = 32'(r_in.label_id) < 32'(LABEL_DEPTH);

    always_comb begin
        case (w_op)
            OP_APPEND_DATA: w_mem_addr = 32'(w_app_d);
            OP_APPEND_TEXT: w_mem_addr = 32'(w_app_t);
            default:        w_mem_addr = 32'(w_acc);
        endcase
    end
    assign w_mem_idx = w_mem_addr[AW-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if ((w_op == OP_READ_DATA || w_op == OP_READ_TEXT)
                    && (!r_in.by_label || w_lbl_rd.valid) && w_in_sec) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_READ: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_done      = 1'b0;
        n_rd_flag   = 1'b0;
        n_res_addr  = r_res_addr;
        n_status    = r_status;
        n_data_fill = r_data_fill;
        n_text_fill = r_text_fill;
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_lbl_wr    = '{en: 1'b0, id: r_in.label_id, target: w_here};
        if (r_state == S_READ) begin
            n_done    = 1'b1;
            n_rd_flag = 1'b1;
        end else if (r_state == S_EXEC) begin
            n_done     = 1'b1;
            n_res_addr = '0;
            n_status   = ST_OK;
            case (w_op) inside
                OP_APPEND_DATA: begin
                    if (w_app_d_ok) begin
                        w_mem_we    = 1'b1;
                        n_data_fill = r_data_fill + 13'd1;
                        n_res_addr  = w_app_d[12:0];
                    end else begin
                        n_status = ST_DATA_FULL;
                    end
                end
                OP_APPEND_TEXT: begin
                    if (w_app_t_ok) begin
                        w_mem_we    = 1'b1;
                        n_text_fill = r_text_fill + 13'd1;
                        n_res_addr  = w_app_t[12:0];
                    end else begin
                        n_status = ST_TEXT_FULL;
                    end
                end
                OP_WRITE_DATA, OP_READ_DATA, OP_READ_TEXT: begin
                    if (r_in.by_label && !w_lbl_rd.valid) begin
                        n_status = ST_NO_LABEL;
                    end else if (!w_in_sec) begin
                        n_status = ST_INVALID;
                    end else begin
                        n_res_addr = w_acc;
                        if (w_op == OP_WRITE_DATA) begin
                            w_mem_we = 1'b1;
                        end else begin
                            w_mem_re = 1'b1;
                            n_done   = 1'b0;
                        end
                    end
                end
                OP_BIND_LABEL, OP_BIND_HERE: begin
                    if (!w_lbl_in_range) begin
                        n_status = ST_INVALID;
                    end else begin
                        w_lbl_wr.en = 1'b1;
                        if (w_op == OP_BIND_LABEL) begin
                            w_lbl_wr.target = {1'b0, r_in.word_address};
                        end
                        n_res_addr = w_lbl_wr.target;
                    end
                end
                default: begin
                    if (w_lbl_rd.valid) begin
                        n_res_addr = w_lbl_rd.target;
                    end else begin
                        n_status = ST_NO_LABEL;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_rd_flag    <= 1'b0;
            r_data_fill  <= '0;
            r_text_fill  <= '0;
            r_data_start <= 13'd0;
            r_text_start <= 13'd2048;
            r_mem_size   <= 13'd4096;
        end else begin
            r_state     <= n_state;
            r_done      <= n_done;
            r_rd_flag   <= n_rd_flag;
            r_data_fill <= n_data_fill;
            r_text_fill <= n_text_fill;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_DATA_START: r_data_start <= i_cfg_data;
                    CFG_TEXT_START: r_text_start <= i_cfg_data;
                    CFG_MEM_SIZE:   r_mem_size   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
        r_res_addr <= n_res_addr;
        r_status   <= n_status;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem_words[w_mem_idx] <= r_in.word_value;
        end
        if (w_mem_re) begin
            r_rdata <= mem_words[w_mem_idx];
        end
    end

    assign o_done               = r_done;
    assign o_out.read_value     = r_rd_flag ? r_rdata : '0;
    assign o_out.result_address = r_res_addr;
    assign o_out.status         = r_status;

`ifndef ASSERT_OFF
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (r_state == S_EXEC))
        else $error("accepted transaction did not enter execution");

    a_exec_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (o_done || r_state == S_READ))
        else $error("execution ended without a result or a read");

    a_done_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result delivered while still busy");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_out.status != ST_OK) |-> (o_out.read_value == '0
            && o_out.result_address == '0))
        else $error("error result carries nonzero fields");
`endif

endmodule
